/* src/prs_pkg.sv */
// Shared types and constants of the polyphase row resampler.
// No dependencies; prs_front, prs_back and the top level import this package.
package prs_pkg;

   // default sizes handed to the top level
   localparam int DEF_MAX_ROW    = 4096;
   localparam int DEF_MAX_TAPS   = 16;
   localparam int DEF_MAX_PHASES = 64;

   // arithmetic constants
   localparam int BIAS_BITS  = 6;
   localparam int COEF_BITS  = 14;
   localparam int PIX_MAX    = 255;
   localparam int RESULT_CAP = 64;

   // queue depths between the parts
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_COUNT  = 3'd3;

   // input item codes
   localparam logic ACT_LOAD_COEF = 1'b0;
   localparam logic ACT_SAMPLE    = 1'b1;

   // classified input item
   typedef struct packed {
      logic               is_sample;
      logic               coef_ok;
      logic [9:0]         coef_address;
      logic signed [15:0] coef_value;
      logic signed [15:0] sample_value;
   } cmd_type;

   // raw configuration registers
   typedef struct packed {
      logic [12:0] source_width;
      logic [12:0] target_width;
      logic [4:0]  tap_count;
      logic [6:0]  phase_count;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic [7:0]  pixel;
      logic [11:0] pixel_position;
      logic        row_done;
   } rsp_type;

endpackage

/* src/prs_fifo.sv */
// Small register queue used for the command and result transfers.
// Depends on nothing but its parameters.
module prs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[head_ff];

   // advance pointers and count
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + PW'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= din;
      end
   end

endmodule

/* src/prs_front.sv */
// Front part: accepts input items, classifies them, holds the configuration.
// Depends on prs_pkg.
module prs_front import prs_pkg::*; #(
   parameter int MAX_TAPS   = DEF_MAX_TAPS,
   parameter int MAX_PHASES = DEF_MAX_PHASES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_action,
   input  logic [9:0]            req_coef_address,
   input  logic signed [15:0]    req_coef_value,
   input  logic signed [15:0]    req_sample_value,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  cmd_push,
   output cmd_type               cmd,
   input  logic                  cmd_full,
   output cfg_type               cfg,
   output logic                  cfg_restart
);
   localparam int COEF_DEPTH = MAX_PHASES * MAX_TAPS;

   cfg_type cfg_ff, cfg_in;
   logic    known_index;

   assign req_full  = cmd_full;
   assign cmd_push  = req_push && !cmd_full;
   assign csr_ready = 1'b1;

   // classify the item
   always_comb begin
      cmd.is_sample    = (req_action == ACT_SAMPLE);
      cmd.coef_ok      = (32'(req_coef_address) < COEF_DEPTH);
      cmd.coef_address = req_coef_address;
      cmd.coef_value   = req_coef_value;
      cmd.sample_value = req_sample_value;
   end

   // decode register writes
   always_comb begin
      cfg_in      = cfg_ff;
      known_index = 1'b1;
      case (csr_index)
         CSR_SOURCE_WIDTH: cfg_in.source_width = csr_data;
         CSR_TARGET_WIDTH: cfg_in.target_width = csr_data;
         CSR_TAP_COUNT:    cfg_in.tap_count    = csr_data[4:0];
         CSR_PHASE_COUNT:  cfg_in.phase_count  = csr_data[6:0];
         default:          known_index         = 1'b0;
      endcase
   end

   assign cfg_restart = csr_valid && known_index;
   assign cfg         = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width <= 13'd1;
         cfg_ff.target_width <= 13'd1;
         cfg_ff.tap_count    <= 5'd2;
         cfg_ff.phase_count  <= 7'd1;
      end else if (csr_valid) begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/prs_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module prs_div #(
   parameter int NUM_W = 8,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [CW-1:0]    cnt_ff;
   logic             run_ff, done_ff;
   logic [DEN_W:0]   shifted, diff;
   logic             ge;

   // one trial subtraction
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CW'(NUM_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath holds no reset
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         rem_ff <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

/* src/prs_back.sv */
// Back part: row and coefficient stores, tap sequencer, border division.
// Depends on prs_pkg and prs_div.
module prs_back import prs_pkg::*; #(
   parameter int MAX_ROW    = DEF_MAX_ROW,
   parameter int MAX_TAPS   = DEF_MAX_TAPS,
   parameter int MAX_PHASES = DEF_MAX_PHASES
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cfg_restart,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    res_full,
   output logic    res_push,
   output rsp_type res
);
   localparam int ROW_IW     = $clog2(MAX_ROW);
   localparam int SW_W       = $clog2(MAX_ROW + 1);
   localparam int TAP_W      = $clog2(MAX_TAPS + 1);
   localparam int PP_W       = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
   localparam int COEF_DEPTH = MAX_PHASES * MAX_TAPS;
   localparam int COEF_IW    = $clog2(COEF_DEPTH);
   localparam int LW         = ((SW_W > TAP_W) ? SW_W : TAP_W) + 1;
   localparam int SX_W       = LW + 1;
   localparam int ACC_W      = 33 + $clog2(MAX_TAPS);
   localparam int DEN_W      = 17 + $clog2(MAX_TAPS);
   localparam int DVS_W      = DEN_W + BIAS_BITS;
   localparam int MB_W       = TAP_W + SW_W + 1;
   localparam int NA_W       = (ACC_W > MB_W) ? ACC_W : MB_W;
   localparam int DIVN_W     = (NA_W > 2 * SW_W) ? NA_W : 2 * SW_W;
   localparam int DIVD_W     = (DVS_W > SW_W) ? DVS_W : SW_W;
   localparam int CNT_W      = $clog2(RESULT_CAP + 1);
   localparam logic signed [ACC_W-1:0] ROUND =
      ACC_W'(1) << (COEF_BITS + BIAS_BITS - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_SETUP_MUL, ST_DIV_START, ST_DIV_WAIT,
      ST_EQ_RD, ST_EQ_CALC, ST_TAPS, ST_BORDER_DIV, ST_BORDER_WAIT, ST_EMIT
   } state_type;

   // saturate the registers for use
   function automatic logic [SW_W-1:0] sat_row(input logic [12:0] v);
      if (v == '0) return SW_W'(1);
      else if (32'(v) > MAX_ROW) return SW_W'(MAX_ROW);
      else return SW_W'(v);
   endfunction

   function automatic logic [7:0] clamp_pix(input logic [DIVN_W-1:0] v);
      if (v > DIVN_W'(PIX_MAX)) return 8'(PIX_MAX);
      else return v[7:0];
   endfunction

   logic [SW_W-1:0]  sw, tw;
   logic [TAP_W-1:0] taps, half;
   logic [PP_W:0]    phases;
   logic             eq;

   always_comb begin
      sw = sat_row(cfg.source_width);
      tw = sat_row(cfg.target_width);
      if (cfg.tap_count < 5'd2) taps = TAP_W'(2);
      else if (32'(cfg.tap_count) > MAX_TAPS) taps = TAP_W'(MAX_TAPS);
      else taps = TAP_W'(cfg.tap_count);
      if (cfg.phase_count == '0) phases = (PP_W + 1)'(1);
      else if (32'(cfg.phase_count) > MAX_PHASES) phases = (PP_W + 1)'(MAX_PHASES);
      else phases = (PP_W + 1)'(cfg.phase_count);
      half = taps >> 1;
      eq   = (sw == tw);
   end

   state_type               state_ff, state_in;
   logic [SW_W-1:0]         sr_ff, sr_in, x_ff, x_in;
   logic [PP_W-1:0]         phase_ff, phase_in;
   logic [COEF_IW-1:0]      base_ff, base_in;
   logic [SW_W-1:0]         q_ff, q_in, r_ff, r_in, qs_ff, qs_in, rs_ff, rs_in;
   logic [DIVN_W-1:0]       mb_ff, mb_in, me_ff, me_in, prod0_ff, prod0_in;
   logic                    setup_ff, setup_in;
   logic [1:0]              step_ff, step_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [TAP_W-1:0]        issue_ff, issue_in;
   logic signed [ACC_W-1:0] nume_ff, nume_in;
   logic signed [DEN_W-1:0] deno_ff, deno_in;
   logic [7:0]              pix_ff, pix_in;
   logic                    neg_ff, neg_in;

   // tap pipeline
   logic                    s1_v_ff, s1_in_ff, s2_v_ff, s2_in_ff;
   logic signed [15:0]      row_rd_ff, coef_rd_ff, coef2_ff;
   logic signed [31:0]      prod_ff;

   // store ports
   logic                    row_we, coef_we, issue_go;
   logic [ROW_IW-1:0]       row_waddr, row_raddr;
   logic [COEF_IW-1:0]      coef_waddr, coef_raddr;

   // divider port
   logic                    div_start, div_done;
   logic [DIVN_W-1:0]       div_num, div_quo;
   logic [DIVD_W-1:0]       div_den, div_rem;

   // per-pixel values
   logic signed [SX_W-1:0]  sx;
   logic                    inrange;
   logic [LW-1:0]           last, lastc;
   logic                    ready, interior, drained, last_col;
   logic signed [ACC_W-1:0] vb, shr;
   logic [ACC_W-1:0]        vmag;
   logic [DEN_W-1:0]        dmag;
   logic signed [16:0]      ev;

   always_comb begin
      sx = $signed(SX_W'(q_ff)) + $signed(SX_W'(issue_ff)) + $signed(SX_W'(1))
           - $signed(SX_W'(half));
      inrange  = !sx[SX_W-1] && (sx < $signed(SX_W'(sw)));
      last     = LW'(q_ff) + LW'(taps) - LW'(half);
      lastc    = (last > LW'(sw) - LW'(1)) ? LW'(sw) - LW'(1) : last;
      ready    = (lastc < LW'(sr_ff));
      interior = (DIVN_W'(x_ff) >= mb_ff) && (DIVN_W'(x_ff) < me_ff);
      drained  = (issue_ff == taps) && !s1_v_ff && !s2_v_ff;
      last_col = (x_ff == tw - SW_W'(1));
      vb       = nume_ff + ROUND;
      shr      = vb >>> (COEF_BITS + BIAS_BITS);
      vmag     = vb[ACC_W-1] ? ACC_W'(-vb) : ACC_W'(vb);
      dmag     = deno_ff[DEN_W-1] ? DEN_W'(-deno_ff) : DEN_W'(deno_ff);
      ev       = $signed({row_rd_ff[15], row_rd_ff}) + 17'sd32;
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      sr_in     = sr_ff;
      x_in      = x_ff;
      phase_in  = phase_ff;
      base_in   = base_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      qs_in     = qs_ff;
      rs_in     = rs_ff;
      mb_in     = mb_ff;
      me_in     = me_ff;
      prod0_in  = prod0_ff;
      setup_in  = setup_ff;
      step_in   = step_ff;
      n_in      = n_ff;
      issue_in  = issue_ff;
      nume_in   = nume_ff;
      deno_in   = deno_ff;
      pix_in    = pix_ff;
      neg_in    = neg_ff;
      cmd_pop   = 1'b0;
      res_push  = 1'b0;
      row_we    = 1'b0;
      coef_we   = 1'b0;
      issue_go  = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      row_waddr  = sr_ff[ROW_IW-1:0];
      coef_waddr = COEF_IW'(cmd.coef_address);
      row_raddr  = (state_ff == ST_TAPS) ? sx[ROW_IW-1:0] : x_ff[ROW_IW-1:0];
      coef_raddr = COEF_IW'(base_ff + COEF_IW'(issue_ff));
      res.pixel          = pix_ff;
      res.pixel_position = 12'(x_ff);
      res.row_done       = last_col;

      // accumulate finished products
      if (s2_v_ff && s2_in_ff) begin
         nume_in = nume_ff + ACC_W'(prod_ff);
         deno_in = deno_ff + DEN_W'(coef2_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (!cmd.is_sample) begin
                  coef_we = cmd.coef_ok;
               end else begin
                  if (sr_ff < sw) begin
                     row_we = 1'b1;
                     sr_in  = sr_ff + SW_W'(1);
                  end
                  n_in     = '0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (n_ff == CNT_W'(RESULT_CAP) || x_ff >= tw) begin
               state_in = ST_IDLE;
            end else if (eq) begin
               state_in = (x_ff < sr_ff) ? ST_EQ_RD : ST_IDLE;
            end else if (!setup_ff) begin
               step_in  = 2'd0;
               state_in = ST_SETUP_MUL;
            end else if (ready) begin
               issue_in = '0;
               nume_in  = '0;
               deno_in  = '0;
               state_in = ST_TAPS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP_MUL: begin
            if (step_ff == 2'd1) begin
               prod0_in = DIVN_W'((2 * SW_W)'(half - TAP_W'(1)) * (2 * SW_W)'(tw));
            end else begin
               prod0_in = DIVN_W'((2 * SW_W)'(sw - SW_W'(half)) * (2 * SW_W)'(tw));
            end
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            case (step_ff)
               2'd0: begin
                  div_start = 1'b1;
                  div_num   = DIVN_W'(sw);
                  div_den   = DIVD_W'(tw);
                  state_in  = ST_DIV_WAIT;
               end
               2'd1: begin
                  div_start = 1'b1;
                  div_num   = prod0_ff + DIVN_W'(sw) - DIVN_W'(1);
                  div_den   = DIVD_W'(sw);
                  state_in  = ST_DIV_WAIT;
               end
               default: begin
                  if (LW'(sw) <= LW'(half)) begin
                     me_in    = '0;
                     setup_in = 1'b1;
                     state_in = ST_CHECK;
                  end else begin
                     div_start = 1'b1;
                     div_num   = prod0_ff;
                     div_den   = DIVD_W'(sw);
                     state_in  = ST_DIV_WAIT;
                  end
               end
            endcase
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               case (step_ff)
                  2'd0: begin
                     qs_in = SW_W'(div_quo);
                     rs_in = SW_W'(div_rem);
                  end
                  2'd1:    mb_in = div_quo;
                  default: me_in = div_quo;
               endcase
               if (step_ff == 2'd2) begin
                  setup_in = 1'b1;
                  state_in = ST_CHECK;
               end else begin
                  step_in  = step_ff + 2'd1;
                  state_in = ST_SETUP_MUL;
               end
            end
         end
         ST_EQ_RD: begin
            state_in = ST_EQ_CALC;
         end
         ST_EQ_CALC: begin
            pix_in   = ev[16] ? 8'd0 : clamp_pix(DIVN_W'(ev >>> BIAS_BITS));
            state_in = ST_EMIT;
         end
         ST_TAPS: begin
            if (issue_ff != taps) begin
               issue_go = 1'b1;
               issue_in = issue_ff + TAP_W'(1);
            end else if (drained) begin
               if (interior) begin
                  pix_in   = vb[ACC_W-1] ? 8'd0 : clamp_pix(DIVN_W'(shr));
                  state_in = ST_EMIT;
               end else if (deno_ff == '0) begin
                  pix_in   = 8'd0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_BORDER_DIV;
               end
            end
         end
         ST_BORDER_DIV: begin
            div_start = 1'b1;
            div_num   = DIVN_W'(vmag);
            div_den   = DIVD_W'(dmag) << BIAS_BITS;
            neg_in    = vb[ACC_W-1] ^ deno_ff[DEN_W-1];
            state_in  = ST_BORDER_WAIT;
         end
         ST_BORDER_WAIT: begin
            if (div_done) begin
               pix_in   = neg_ff ? 8'd0 : clamp_pix(div_quo);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!res_full) begin
               res_push = 1'b1;
               n_in     = n_ff + CNT_W'(1);
               if (last_col) begin
                  x_in     = '0;
                  sr_in    = '0;
                  phase_in = '0;
                  base_in  = '0;
                  q_in     = '0;
                  r_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  x_in = x_ff + SW_W'(1);
                  if ((PP_W + 1)'(phase_ff) + (PP_W + 1)'(1) >= phases) begin
                     phase_in = '0;
                     base_in  = '0;
                  end else begin
                     phase_in = phase_ff + PP_W'(1);
                     base_in  = base_ff + COEF_IW'(taps);
                  end
                  // step the source origin by source/target
                  if ((LW'(r_ff) + LW'(rs_ff)) >= LW'(tw)) begin
                     r_in = SW_W'(LW'(r_ff) + LW'(rs_ff) - LW'(tw));
                     q_in = q_ff + qs_ff + SW_W'(1);
                  end else begin
                     r_in = r_ff + rs_ff;
                     q_in = q_ff + qs_ff;
                  end
                  state_in = ST_CHECK;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // register write restarts the row
      if (cfg_restart) begin
         sr_in    = '0;
         x_in     = '0;
         phase_in = '0;
         base_in  = '0;
         q_in     = '0;
         r_in     = '0;
         setup_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sr_ff    <= '0;
         x_ff     <= '0;
         phase_ff <= '0;
         base_ff  <= '0;
         q_ff     <= '0;
         r_ff     <= '0;
         setup_ff <= 1'b0;
         step_ff  <= '0;
         n_ff     <= '0;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         sr_ff    <= sr_in;
         x_ff     <= x_in;
         phase_ff <= phase_in;
         base_ff  <= base_in;
         q_ff     <= q_in;
         r_ff     <= r_in;
         setup_ff <= setup_in;
         step_ff  <= step_in;
         n_ff     <= n_in;
         issue_ff <= issue_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      qs_ff    <= qs_in;
      rs_ff    <= rs_in;
      mb_ff    <= mb_in;
      me_ff    <= me_in;
      prod0_ff <= prod0_in;
      nume_ff  <= nume_in;
      deno_ff  <= deno_in;
      pix_ff   <= pix_in;
      neg_ff   <= neg_in;
      prod_ff  <= row_rd_ff * coef_rd_ff;
      coef2_ff <= coef_rd_ff;
   end

   // tap pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s1_in_ff <= 1'b0;
         s2_v_ff  <= 1'b0;
         s2_in_ff <= 1'b0;
      end else begin
         s1_v_ff  <= issue_go;
         s1_in_ff <= issue_go && inrange;
         s2_v_ff  <= s1_v_ff;
         s2_in_ff <= s1_in_ff;
      end
   end

   // row store
   logic signed [15:0] row_mem [MAX_ROW];
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= cmd.sample_value;
      end
      row_rd_ff <= row_mem[row_raddr];
   end

   // coefficient store
   logic signed [15:0] coef_mem [COEF_DEPTH];
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= cmd.coef_value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   prs_div #(
      .NUM_W(DIVN_W),
      .DEN_W(DIVD_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quo  (div_quo),
      .rem  (div_rem)
   );

`ifndef ASSERT_OFF
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result transfer into a full queue");

   a_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (n_ff <= CNT_W'(RESULT_CAP)))
      else $error("more results than one step allows");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE) && cmd_valid)
      else $error("command taken outside idle");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      (res_push && res.row_done && !cfg_restart) |=> (x_ff == '0) && (sr_ff == '0))
      else $error("row state not cleared after last pixel");
`endif

endmodule

/* src/polyphase_row_resampler.sv */
// Top level of the horizontal polyphase row resampler.
// Depends on prs_pkg, prs_fifo, prs_front, prs_back (and prs_div below it).
//
//  channel  direction  handshake            content
//  req_     in         push / full          coefficient load or row sample
//  rsp_     out        pop / empty          pixel, column, row end flag
//  csr_     in         valid / ready        register index and data
//
// A coefficient load passes the command queue and is written to its store
// by the back part. A sample step writes the sample, then for each pixel it
// releases runs the taps through the tap pipeline inside the row, and also
// runs the shared divider at the borders; equal widths pass the stored
// sample through rounding. After a register write the first pixel of a row
// waits for up to three divider runs of row setup.
// Reset is synchronous and needs no clearing pass; both stores start unset.
// A full result queue stalls the back part, the command queue then the input.
module polyphase_row_resampler import prs_pkg::*; #(
   parameter int MAX_ROW    = DEF_MAX_ROW,
   parameter int MAX_TAPS   = DEF_MAX_TAPS,
   parameter int MAX_PHASES = DEF_MAX_PHASES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_action,
   input  logic [9:0]            req_coef_address,
   input  logic signed [15:0]    req_coef_value,
   input  logic signed [15:0]    req_sample_value,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_pixel,
   output logic [11:0]           rsp_pixel_position,
   output logic                  rsp_row_done,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   cmd_type cmd_wr, cmd_rd;
   cfg_type cfg;
   rsp_type res, rsp;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop, cfg_restart;
   logic    res_push, res_full;

   prs_front #(
      .MAX_TAPS  (MAX_TAPS),
      .MAX_PHASES(MAX_PHASES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_action      (req_action),
      .req_coef_address(req_coef_address),
      .req_coef_value  (req_coef_value),
      .req_sample_value(req_sample_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd_push        (cmd_push),
      .cmd             (cmd_wr),
      .cmd_full        (cmd_full),
      .cfg             (cfg),
      .cfg_restart     (cfg_restart)
   );

   // queue between front and back
   prs_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_q (
      .clock(clock),
      .reset(reset),
      .push (cmd_push),
      .din  (cmd_wr),
      .full (cmd_full),
      .pop  (cmd_pop),
      .dout (cmd_rd),
      .empty(cmd_empty)
   );

   prs_back #(
      .MAX_ROW   (MAX_ROW),
      .MAX_TAPS  (MAX_TAPS),
      .MAX_PHASES(MAX_PHASES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cfg_restart(cfg_restart),
      .cmd_valid  (!cmd_empty),
      .cmd        (cmd_rd),
      .cmd_pop    (cmd_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res        (res)
   );

   // result queue
   prs_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_q (
      .clock(clock),
      .reset(reset),
      .push (res_push),
      .din  (res),
      .full (res_full),
      .pop  (rsp_pop),
      .dout (rsp),
      .empty(rsp_empty)
   );

   assign rsp_pixel          = rsp.pixel;
   assign rsp_pixel_position = rsp.pixel_position;
   assign rsp_row_done       = rsp.row_done;

endmodule
